// ----- design/pbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants
// State encoding, root/divide unit control and the fixed widths of the block.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int POS_W      = 32;
    localparam int WGT_W      = 17;
    localparam int GRAD_W     = 18;
    localparam int NUM_SLOTS  = 5;
    localparam int SQRT_STEPS = 44;
    localparam int DIV_STEPS  = 61;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_WSUM,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT,
        ST_DIV_GO,
        ST_DIV,
        ST_GRAD,
        ST_OUT
    } t_state;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } t_rd_mode;

    typedef struct packed {
        logic     start;
        t_rd_mode mode;
    } t_rd_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rd_stat;

endpackage

// ----- design/pbd_in_if.sv -----
// ----------------------------------------------------------------------------
// pbd_in_if: position input channel
// One word carries the slot tag and the three coordinates of a particle.
// ----------------------------------------------------------------------------
interface pbd_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, slot, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, slot, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- design/pbd_out_if.sv -----
// ----------------------------------------------------------------------------
// pbd_out_if: gradient output channel
// One word carries the gradient of one particle and the constraint value.
// ----------------------------------------------------------------------------
interface pbd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         grad_slot;
    logic signed [17:0] grad_x;
    logic signed [17:0] grad_y;
    logic signed [17:0] grad_z;
    logic [31:0]        distance;
    logic               active;
    logic               last;

    modport source (output valid, grad_slot, grad_x, grad_y, grad_z, distance, active, last,
                    input ready);
    modport sink   (input valid, grad_slot, grad_x, grad_y, grad_z, distance, active, last,
                    output ready);
endinterface

// ----- design/pbd_mul.sv -----
// ----------------------------------------------------------------------------
// pbd_mul: shared multiplier
// Unsigned 36 x 18 multiply with a registered product.
// ----------------------------------------------------------------------------
module pbd_mul
    import pbd_pkg::*;
(
    input  logic        i_clk,
    input  logic [35:0] i_a,
    input  logic [17:0] i_b,
    output logic [53:0] o_p
);
    logic [53:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {18'b0, i_a} * {36'b0, i_b};
    end

    assign o_p = r_p;
endmodule

// ----- design/pbd_root_div.sv -----
// ----------------------------------------------------------------------------
// pbd_root_div: bit-serial square root and divider
// One shared compare/subtract resolves one result bit per cycle.
// ----------------------------------------------------------------------------
module pbd_root_div
    import pbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rd_ctrl    i_ctrl,
    input  logic [87:0] i_num,
    input  logic [43:0] i_den,
    output t_rd_stat    o_stat,
    output logic [43:0] o_res
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    t_rd_mode    r_mode;
    logic [46:0] r_rem;
    logic [87:0] r_num;
    logic [43:0] r_res;
    logic [43:0] r_den;

    logic [46:0] cur;
    logic [46:0] trial;
    logic [47:0] diff;
    logic        ge;

    always_comb begin
        unique case (r_mode)
            RD_SQRT: begin
                cur   = {r_rem[44:0], r_num[87:86]};
                trial = {1'b0, r_res, 2'b01};
            end
            RD_DIV: begin
                cur   = {r_rem[45:0], r_num[87]};
                trial = {3'b0, r_den};
            end
        endcase
        diff = {1'b0, cur} - {1'b0, trial};
        ge   = ~diff[47];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= RD_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctrl.mode;
                r_cnt  <= (i_ctrl.mode == RD_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_res <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[46:0] : cur;
            r_res <= {r_res[42:0], ge};
            r_num <= (r_mode == RD_SQRT) ? {r_num[85:0], 2'b00} : {r_num[86:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("root/divide unit started while busy");
`endif
endmodule

// ----- design/pbd_insertion_constraint_gradient_top.sv -----
// ----------------------------------------------------------------------------
// pbd_insertion_constraint_gradient_top: thread insertion constraint gradient
// Loads five particle positions and emits five distance-constraint gradients.
// ----------------------------------------------------------------------------
// A position word that does not complete the set of five slots is taken. The
// word that completes the set starts the evaluation, and the block stays busy
// until the last gradient word is taken, including any output stall. The
// evaluation forms weighted sums and squares on the shared multiplier, then
// the 44-step bit-serial square root with its start and hand-off states.
// Three 61-step divisions follow on the same root/divide unit, and each of
// the five gradient words is built on the multiplier and then held on the
// output until it is taken. When the two points coincide, the root and the
// divisions are skipped. Input is not ready during the evaluation.
module pbd_insertion_constraint_gradient_top
    import pbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbd_in_if.sink     i_in,
    pbd_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    t_state             r_state, n_state;
    logic [4:0]         r_mask, n_mask;
    logic [2:0]         r_sl, n_sl;
    logic [1:0]         r_ax, n_ax;
    logic               r_ph, n_ph;
    logic               r_half, n_half;
    logic [2:0]         r_k, n_k;
    logic signed [51:0] r_acc, n_acc;
    logic               r_psign, n_psign;
    logic signed [35:0] r_t, n_t;
    logic signed [36:0] r_d [0:2];
    logic signed [36:0] n_d [0:2];
    logic [71:0]        r_s, n_s;
    logic [43:0]        r_n, n_n;
    logic [31:0]        r_dist, n_dist;
    logic               r_active, n_active;
    logic [16:0]        r_u [0:2];
    logic [16:0]        n_u [0:2];
    logic [17:0]        r_g [0:2];
    logic [17:0]        n_g [0:2];

    logic signed [31:0] r_pos [0:4][0:2];
    logic [16:0]        r_w [0:4];

    logic [35:0]        mul_a;
    logic [17:0]        mul_b;
    logic [53:0]        prod;
    t_rd_ctrl           rd_ctrl;
    t_rd_stat           rd_stat;
    logic [87:0]        rd_num;
    logic [43:0]        rd_res;

    logic signed [31:0] p_sel;
    logic [31:0]        p_mag;
    logic signed [51:0] term, acc_sum, rounded;
    logic [35:0]        d_mag;
    logic [4:0]         mask_new;
    logic [17:0]        uq, gr, gm;
    logic               neg;

    pbd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    pbd_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rd_ctrl),
        .i_num   (rd_num),
        .i_den   (r_n),
        .o_stat  (rd_stat),
        .o_res   (rd_res)
    );

    assign i_in.ready = (r_state == ST_LOAD);

    always_comb begin
        p_sel   = r_pos[r_sl][r_ax];
        p_mag   = p_sel[31] ? 32'(-p_sel) : 32'(p_sel);
        term    = r_psign ? -$signed({4'b0, prod[47:0]}) : $signed({4'b0, prod[47:0]});
        acc_sum = r_acc + term;
        rounded = acc_sum + 52'sh8000;
        d_mag   = r_d[r_ax][36] ? 36'(-r_d[r_ax]) : r_d[r_ax][35:0];
        // The quotient carries one extra fraction bit; halve it, rounding up.
        uq      = {1'b0, rd_res[17:1]} + {17'b0, rd_res[0]};
        gr      = 18'((prod[33:0] + 34'h8000) >> 16);
        gm      = (gr > 18'h10000) ? 18'h10000 : gr;
        neg     = r_d[r_ax][36] ^ (r_k >= 3'd2);
        mask_new = r_mask | (5'd1 << i_in.slot);
    end

    always_comb begin
        n_state  = r_state;
        n_mask   = r_mask;
        n_sl     = r_sl;
        n_ax     = r_ax;
        n_ph     = r_ph;
        n_half   = r_half;
        n_k      = r_k;
        n_acc    = r_acc;
        n_psign  = r_psign;
        n_t      = r_t;
        n_d      = r_d;
        n_s      = r_s;
        n_n      = r_n;
        n_dist   = r_dist;
        n_active = r_active;
        n_u      = r_u;
        n_g      = r_g;
        mul_a    = '0;
        mul_b    = '0;
        rd_ctrl.start = 1'b0;
        rd_ctrl.mode  = RD_SQRT;
        rd_num   = {r_s, 16'b0};

        unique case (r_state)
            ST_LOAD: begin
                if (i_in.valid && i_in.slot < 3'(NUM_SLOTS)) begin
                    if (mask_new == 5'h1F) begin
                        n_mask  = '0;
                        n_state = ST_WSUM;
                        n_sl    = '0;
                        n_ax    = '0;
                        n_ph    = 1'b0;
                        n_acc   = '0;
                    end else begin
                        n_mask = mask_new;
                    end
                end
            end
            ST_WSUM: begin
                mul_a = {4'b0, p_mag};
                mul_b = {1'b0, r_w[r_sl]};
                if (!r_ph) begin
                    n_psign = p_sel[31];
                    n_ph    = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_sl == 3'd1) begin
                        n_t   = rounded[51:16];
                        n_acc = '0;
                    end else if (r_sl == 3'd4) begin
                        n_d[r_ax] = {rounded[51], rounded[51:16]} - {r_t[35], r_t};
                        n_acc     = '0;
                    end else begin
                        n_acc = acc_sum;
                    end
                    if (r_sl == 3'd4) begin
                        n_sl = '0;
                        if (r_ax == 2'd2) begin
                            n_state = ST_SQ;
                            n_ax    = '0;
                            n_half  = 1'b0;
                            n_s     = '0;
                        end else begin
                            n_ax = r_ax + 2'd1;
                        end
                    end else begin
                        n_sl = r_sl + 3'd1;
                    end
                end
            end
            ST_SQ: begin
                // The square of each component is built from two partial products.
                mul_a = d_mag;
                mul_b = r_half ? d_mag[35:18] : d_mag[17:0];
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph   = 1'b0;
                    n_s    = r_s + (r_half ? {prod, 18'b0} : {18'b0, prod});
                    n_half = ~r_half;
                    if (r_half) begin
                        if (r_ax == 2'd2) begin
                            n_ax = '0;
                            if (r_d[0] != '0 || r_d[1] != '0 || r_d[2] != '0) begin
                                n_state = ST_SQRT_GO;
                            end else begin
                                n_u[0]   = '0;
                                n_u[1]   = '0;
                                n_u[2]   = '0;
                                n_dist   = '0;
                                n_active = 1'b0;
                                n_k      = '0;
                                n_state  = ST_GRAD;
                            end
                        end else begin
                            n_ax = r_ax + 2'd1;
                        end
                    end
                end
            end
            ST_SQRT_GO: begin
                rd_ctrl.start = 1'b1;
                rd_ctrl.mode  = RD_SQRT;
                n_state       = ST_SQRT;
            end
            ST_SQRT: begin
                if (rd_stat.done) begin
                    n_n      = rd_res;
                    n_dist   = (rd_res[43:40] != 4'd0) ? 32'hFFFF_FFFF : rd_res[39:8];
                    n_active = 1'b1;
                    n_ax     = '0;
                    n_state  = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                rd_ctrl.start = 1'b1;
                rd_ctrl.mode  = RD_DIV;
                rd_num        = {d_mag, 25'b0, 27'b0};
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                if (rd_stat.done) begin
                    n_u[r_ax] = (uq > 18'h10000) ? 17'h10000 : uq[16:0];
                    if (r_ax == 2'd2) begin
                        n_ax    = '0;
                        n_k     = '0;
                        n_ph    = 1'b0;
                        n_state = ST_GRAD;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_GRAD: begin
                mul_a = {19'b0, r_u[r_ax]};
                mul_b = {1'b0, r_w[r_k]};
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph      = 1'b0;
                    n_g[r_ax] = neg ? -gm : gm;
                    if (r_ax == 2'd2) begin
                        n_ax    = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_ax = r_ax + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    if (r_k == 3'd4) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = ST_GRAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_mask  <= '0;
            r_sl    <= '0;
            r_ax    <= '0;
            r_ph    <= 1'b0;
            r_half  <= 1'b0;
            r_k     <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_sl    <= n_sl;
            r_ax    <= n_ax;
            r_ph    <= n_ph;
            r_half  <= n_half;
            r_k     <= n_k;
            if (i_cfg_we && i_cfg_index < 3'(NUM_SLOTS)) begin
                r_w[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_psign  <= n_psign;
        r_t      <= n_t;
        r_d      <= n_d;
        r_s      <= n_s;
        r_n      <= n_n;
        r_dist   <= n_dist;
        r_active <= n_active;
        r_u      <= n_u;
        r_g      <= n_g;
        if (i_in.valid && i_in.ready && i_in.slot < 3'(NUM_SLOTS)) begin
            r_pos[i_in.slot][0] <= i_in.pos_x;
            r_pos[i_in.slot][1] <= i_in.pos_y;
            r_pos[i_in.slot][2] <= i_in.pos_z;
        end
    end

    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.grad_slot = r_k;
    assign o_out.grad_x    = r_g[0];
    assign o_out.grad_y    = r_g[1];
    assign o_out.grad_z    = r_g[2];
    assign o_out.distance  = r_dist;
    assign o_out.active    = r_active;
    assign o_out.last      = (r_k == 3'd4);

`ifndef NO_ASSERTIONS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a gradient word is pending");
    a_mask_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask != 5'h1F)
        else $error("slot mask left full after completion");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("block not idle after the final gradient word");
`endif
endmodule

// ----- tb/tb_pbd_insertion_constraint_gradient_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the thread insertion constraint gradient
// Loads sets of five tagged positions under several weight settings. Every
// gradient word is checked against an independent bit-accurate predictor.
// Both channels take random idle bursts.
// ----------------------------------------------------------------------------
module tb_pbd_insertion_constraint_gradient_top;
    import pbd_pkg::*;

    localparam int LIMIT_CYCLES = 300000;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [2:0] {
        REG_THREAD_W0, REG_THREAD_W1, REG_TRI_W0, REG_TRI_W1, REG_TRI_W2
    } t_reg;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  slot;   // register index for a configuration row
        logic [31:0] x;      // register value for a configuration row
        logic [31:0] y;
        logic [31:0] z;
        bit          zero_grad;
    } t_row;

    typedef struct {
        logic [2:0]         slot;
        logic signed [17:0] gx, gy, gz;
        logic [31:0]        distance;
        logic               active;
        logic               last;
    } t_grad;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    pbd_in_if  in_ch();
    pbd_out_if out_ch();

    pbd_insertion_constraint_gradient_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [31:0] pos_store [5][3];
    logic [4:0]         slot_mask;
    logic [16:0]        weight [5];
    t_grad              grad_queue[$];
    int                 errors = 0;
    bit                 quiet = 0;
    int                 cycles = 0;

    function automatic longint weighted_sum(int first, int count, int axis);
        longint acc = 0;
        for (int i = 0; i < count; i++)
            acc += longint'(pos_store[first + i][axis]) * longint'({1'b0, weight[first + i]});
        return (acc + 64'sd32768) >>> 16;
    endfunction

    // Stores one position word and queues the five gradient words it completes.
    task automatic predict_gradients(logic [2:0] slot, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z, bit zero_grad);
        longint d [3];
        bit [127:0] sq;
        bit [63:0] mag, root, trial, dist_wide, unit [3], g;
        bit active;
        t_grad w;
        if (slot > 3'd4)
            return;
        pos_store[slot][0] = x;
        pos_store[slot][1] = y;
        pos_store[slot][2] = z;
        slot_mask[slot] = 1'b1;
        if (slot_mask != 5'h1F)
            return;
        slot_mask = '0;
        sq = '0;
        active = 0;
        for (int a = 0; a < 3; a++) begin
            d[a] = weighted_sum(2, 3, a) - weighted_sum(0, 2, a);
            mag = d[a] < 0 ? -d[a] : d[a];
            sq += 128'(mag) * 128'(mag);
            if (d[a] != 0)
                active = 1;
            unit[a] = 0;
        end
        dist_wide = 0;
        if (active) begin
            sq = sq << 16;
            root = 0;
            for (int b = 63; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (128'(trial) * 128'(trial) <= sq)
                    root = trial;
            end
            dist_wide = root >> 8;
            if (dist_wide > 64'hFFFF_FFFF)
                dist_wide = 64'hFFFF_FFFF;
            for (int a = 0; a < 3; a++) begin
                mag = d[a] < 0 ? -d[a] : d[a];
                unit[a] = 64'(((128'(mag) << 25) / 128'(root) + 1) >> 1);
                if (unit[a] > 65536)
                    unit[a] = 65536;
            end
        end
        for (int k = 0; k < 5; k++) begin
            w.slot = 3'(k);
            w.distance = zero_grad ? 32'd0 : dist_wide[31:0];
            w.active = zero_grad ? 1'b0 : active;
            w.last = (k == 4);
            for (int a = 0; a < 3; a++) begin
                g = 0;
                if (active && !zero_grad) begin
                    g = (unit[a] * weight[k] + 64'd32768) >> 16;
                    if (g > 65536)
                        g = 65536;
                    if ((d[a] < 0) != (k >= 2))
                        g = -g;
                end
                if (a == 0) w.gx = g[17:0];
                else if (a == 1) w.gy = g[17:0];
                else w.gz = g[17:0];
            end
            grad_queue.push_back(w);
        end
    endtask

    task automatic write_weight(logic [2:0] idx, logic [16:0] value);
        // The block may still be finishing its last word: let it settle.
        wait (grad_queue.size() == 0);
        repeat (10) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        weight[idx] = value;
    endtask

    task automatic send_position(logic [2:0] slot, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, bit zero_grad);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.slot = slot;
        in_ch.pos_x = x;
        in_ch.pos_y = y;
        in_ch.pos_z = z;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_gradients(slot, x, y, z, zero_grad);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd131071;
            2: return 17'd65536;
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    // Receive side: random stall bursts, none in the quiet stretch.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_grad e;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("[pbd_insertion_constraint_gradient_top] ERROR");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (grad_queue.size() == 0) begin
                $display("%0t: unexpected gradient word slot %0d", $time, out_ch.grad_slot);
                errors++;
            end else begin
                e = grad_queue.pop_front();
                if (out_ch.grad_slot !== e.slot || out_ch.grad_x !== e.gx ||
                    out_ch.grad_y !== e.gy || out_ch.grad_z !== e.gz ||
                    out_ch.distance !== e.distance || out_ch.active !== e.active ||
                    out_ch.last !== e.last) begin
                    $display("%0t: expected slot %0d g(%0d,%0d,%0d) dist %0d act %0b last %0b",
                             $time, e.slot, e.gx, e.gy, e.gz, e.distance, e.active, e.last);
                    $display("%0t: actual   slot %0d g(%0d,%0d,%0d) dist %0d act %0b last %0b",
                             $time, out_ch.grad_slot, out_ch.grad_x, out_ch.grad_y,
                             out_ch.grad_z, out_ch.distance, out_ch.active, out_ch.last);
                    errors++;
                end
            end
        end
    end

    t_row directed [] = '{
        // Weights are zero after reset, so both points sit at the origin.
        '{ROW_ITEM, 3'd7, 32'h1234_5678, 32'h0, 32'h0, 0},
        '{ROW_ITEM, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1},
        '{ROW_ITEM, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1},
        '{ROW_ITEM, 3'd2, 32'h0, 32'h0, 32'h0, 1},
        '{ROW_ITEM, 3'd3, 32'hFFFF_FFFF, 32'h1, 32'h0, 1},
        '{ROW_ITEM, 3'd4, 32'h0002_0000, 32'h0, 32'h0, 1},
        '{ROW_CFG, REG_THREAD_W0, 32'd65536, 0, 0, 0},
        '{ROW_CFG, REG_THREAD_W1, 32'd65536, 0, 0, 0},
        '{ROW_CFG, REG_TRI_W0, 32'd65536, 0, 0, 0},
        '{ROW_CFG, REG_TRI_W1, 32'd65536, 0, 0, 0},
        '{ROW_CFG, REG_TRI_W2, 32'd65536, 0, 0, 0},
        // All positions at the origin: the points coincide.
        '{ROW_ITEM, 3'd4, 32'h0, 32'h0, 32'h0, 1},
        '{ROW_ITEM, 3'd3, 32'h0, 32'h0, 32'h0, 1},
        '{ROW_ITEM, 3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
        '{ROW_ITEM, 3'd2, 32'h0, 32'h0, 32'h0, 1},
        '{ROW_ITEM, 3'd1, 32'h0, 32'h0, 32'h0, 1},
        '{ROW_ITEM, 3'd0, 32'h0, 32'h0, 32'h0, 1},
        // Extremes, with a reloaded slot and an ignored one.
        '{ROW_ITEM, 3'd0, 32'h1111_1111, 32'h0, 32'h0, 0},
        '{ROW_ITEM, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0},
        '{ROW_ITEM, 3'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0},
        '{ROW_ITEM, 3'd5, 32'h0, 32'h0, 32'h0, 0},
        '{ROW_ITEM, 3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
        '{ROW_ITEM, 3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
        '{ROW_ITEM, 3'd4, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 0}
    };

    initial begin
        int sent;
        int order [5];
        in_ch.valid = 1'b0;
        in_ch.slot = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        out_ch.ready = 1'b0;
        slot_mask = '0;
        for (int i = 0; i < 5; i++) begin
            weight[i] = '0;
            for (int a = 0; a < 3; a++)
                pos_store[i][a] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG)
                write_weight(directed[r].slot, directed[r].x[16:0]);
            else
                send_position(directed[r].slot, directed[r].x, directed[r].y,
                              directed[r].z, directed[r].zero_grad);
        end
        for (int i = 0; i < 5; i++)
            write_weight(3'(i), 17'd131071);

        sent = 0;
        while (sent < 180) begin
            if (sent > 150)
                quiet = 1;
            if (sent % 40 == 0 && sent > 0)
                for (int i = 0; i < 5; i++)
                    write_weight(3'(i), rand_weight());
            for (int i = 0; i < 5; i++)
                order[i] = i;
            order.shuffle();
            for (int i = 0; i < 5; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // An ignored slot or a reload of an earlier slot.
                    send_position(3'($urandom_range(0, 1) ? $urandom_range(5, 7) : order[0]),
                                  rand_coord(), rand_coord(), rand_coord(), 0);
                end
                send_position(3'(order[i]), rand_coord(), rand_coord(), rand_coord(), 0);
                sent++;
            end
        end

        wait (grad_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[pbd_insertion_constraint_gradient_top] OK");
        else
            $display("[pbd_insertion_constraint_gradient_top] ERROR");
        $finish;
    end
endmodule
